/* rtl/taylor_sine_approximator_macros.svh */
// Assertion macros for the Taylor sine block checker.
// Used by tsa_checker.sv; expects signals clk and rst_n in scope.
`ifndef TAYLOR_SINE_APPROXIMATOR_MACROS_SVH
`define TAYLOR_SINE_APPROXIMATOR_MACROS_SVH

// Antecedent and consequent in the same cycle
`define TSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("taylor sine check failed");

// Consequent in the cycle after the antecedent
`define TSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("taylor sine check failed");

`endif

/* rtl/tsa_pkg.sv */
// Shared types, constants, microcode ROM and rounding helper for the Taylor sine block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

  // Fixed-point formats
  localparam int WORK_FRAC = 28;
  localparam int PW        = 68;  // product width
  localparam int MA        = 35;  // multiplier operand A width (signed)
  localparam int MB        = 33;  // multiplier operand B width (signed)
  localparam int SW        = 34;  // accumulator width

  localparam logic [2:0]  MAX_TERM_COUNT = 3'd5;
  localparam logic [30:0] PI_Q           = 31'd843314857;
  localparam logic [30:0] TWO_PI_Q       = 31'd1686629714;

  // floor(2^62 / TWO_PI_Q), i.e. 2^34 / (2*pi), for the turn-count estimate
  localparam int          RECIP_2PI_SH = 62;
  localparam logic [31:0] RECIP_2PI    = 32'((64'd1 << RECIP_2PI_SH) / 64'(TWO_PI_Q));

  localparam logic [PW-1:0] HALF_28 = PW'(1) << 27;
  localparam logic [PW-1:0] HALF_30 = PW'(1) << 29;

  // Datapath actions, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_PREP,
    OP_MUL_DR,
    OP_MUL_QP,
    OP_REM,
    OP_CORR,
    OP_FIX,
    OP_MUL_XX,
    OP_RND_X2,
    OP_MUL_TX2,
    OP_RND_U,
    OP_MUL_UR,
    OP_RND_T,
    OP_ACC,
    OP_DONE
  } dp_op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ONE_TERM,
    JC_MORE_TERMS
  } jcond_t;

  typedef logic [3:0] upc_t;

  // Program addresses
  localparam upc_t U_PREP   = 4'd0;
  localparam upc_t U_MUL_DR = 4'd1;
  localparam upc_t U_MUL_QP = 4'd2;
  localparam upc_t U_REM    = 4'd3;
  localparam upc_t U_CORR   = 4'd4;
  localparam upc_t U_FIX    = 4'd5;
  localparam upc_t U_MUL_XX = 4'd6;
  localparam upc_t U_RND_X2 = 4'd7;
  localparam upc_t U_TERM   = 4'd8;
  localparam upc_t U_RND_U  = 4'd9;
  localparam upc_t U_MUL_UR = 4'd10;
  localparam upc_t U_RND_T  = 4'd11;
  localparam upc_t U_ACC    = 4'd12;
  localparam upc_t U_DONE   = 4'd13;

  typedef struct packed {
    dp_op_t op;
    jcond_t cond;
    upc_t   target;
  } ucode_word_t;

  // Status flags from datapath to sequencer
  typedef struct packed {
    logic one_term;
    logic more_terms;
  } dp_flags_t;

  // Control program
  function automatic ucode_word_t ucode_rom(input upc_t addr);
    ucode_word_t w;
    case (addr)
      U_PREP:   w = '{op: OP_PREP,    cond: JC_NEXT,       target: U_PREP};
      U_MUL_DR: w = '{op: OP_MUL_DR,  cond: JC_NEXT,       target: U_PREP};
      U_MUL_QP: w = '{op: OP_MUL_QP,  cond: JC_NEXT,       target: U_PREP};
      U_REM:    w = '{op: OP_REM,     cond: JC_NEXT,       target: U_PREP};
      U_CORR:   w = '{op: OP_CORR,    cond: JC_NEXT,       target: U_PREP};
      U_FIX:    w = '{op: OP_FIX,     cond: JC_ONE_TERM,   target: U_DONE};
      U_MUL_XX: w = '{op: OP_MUL_XX,  cond: JC_NEXT,       target: U_PREP};
      U_RND_X2: w = '{op: OP_RND_X2,  cond: JC_NEXT,       target: U_PREP};
      U_TERM:   w = '{op: OP_MUL_TX2, cond: JC_NEXT,       target: U_PREP};
      U_RND_U:  w = '{op: OP_RND_U,   cond: JC_NEXT,       target: U_PREP};
      U_MUL_UR: w = '{op: OP_MUL_UR,  cond: JC_NEXT,       target: U_PREP};
      U_RND_T:  w = '{op: OP_RND_T,   cond: JC_NEXT,       target: U_PREP};
      U_ACC:    w = '{op: OP_ACC,     cond: JC_MORE_TERMS, target: U_TERM};
      U_DONE:   w = '{op: OP_DONE,    cond: JC_NEXT,       target: U_PREP};
      default:  w = '{op: OP_DONE,    cond: JC_NEXT,       target: U_PREP};
    endcase
    return w;
  endfunction

  // Q0.30 reciprocals of (2i)(2i+1)
  function automatic logic [27:0] recip_q30(input logic [2:0] idx);
    logic [27:0] r;
    case (idx)
      3'd0:    r = 28'd178956971;  // 1/6
      3'd1:    r = 28'd53687091;   // 1/20
      3'd2:    r = 28'd25565282;   // 1/42
      3'd3:    r = 28'd14913081;   // 1/72
      3'd4:    r = 28'd9761289;    // 1/110
      default: r = 28'd0;
    endcase
    return r;
  endfunction

  // Right shift by 28 or 30, rounding half away from zero
  function automatic logic signed [PW-1:0] rnd_shr(input logic signed [PW-1:0] p,
                                                   input logic by30);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    m = p[PW-1] ? (~p + PW'(1)) : p;
    r = by30 ? ((m + HALF_30) >> 30) : ((m + HALF_28) >> 28);
    return p[PW-1] ? $signed(~r + PW'(1)) : $signed(r);
  endfunction

endpackage

`default_nettype wire

/* rtl/tsa_ucode_seq.sv */
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on tsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsa_ucode_seq
  import tsa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      start_bad,
  input  wire logic      out_hold,
  input  wire dp_flags_t flags,
  output logic           busy,
  output dp_op_t         exec_op
);

  logic        busy_r, busy_nxt;
  upc_t        upc_r, upc_nxt;
  ucode_word_t cw;
  logic        taken;

  assign cw   = ucode_rom(upc_r);
  assign busy = busy_r;

  // Jump condition
  always_comb begin
    case (cw.cond)
      JC_NEXT:       taken = 1'b0;
      JC_ONE_TERM:   taken = flags.one_term;
      JC_MORE_TERMS: taken = flags.more_terms;
      default:       taken = 1'b0;
    endcase
  end

  // Action issued this cycle; the final step waits for a free output register
  always_comb begin
    if (!busy_r) begin
      exec_op = OP_NOP;
    end else if (cw.op == OP_DONE && out_hold) begin
      exec_op = OP_NOP;
    end else begin
      exec_op = cw.op;
    end
  end

  // Step counter
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        upc_nxt  = start_bad ? U_DONE : U_PREP;
      end
    end else if (cw.op == OP_DONE) begin
      if (!out_hold) begin
        busy_nxt = 1'b0;
      end
    end else begin
      upc_nxt = taken ? cw.target : upc_r + upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= U_PREP;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tsa_mul.sv */
// Shared registered signed multiplier of the series datapath.
// Depends on tsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsa_mul
  import tsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [MA-1:0] a,
  input  wire logic signed [MB-1:0] b,
  output logic signed [PW-1:0]      p
);

  logic signed [PW-1:0] p_r;

  // One product per enabled cycle, held otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= PW'(a) * PW'(b);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

/* rtl/tsa_datapath.sv */
// Datapath: range reduction by reciprocal multiplication, series terms and accumulator.
// Depends on tsa_pkg and tsa_mul.
`timescale 1ns / 1ps
`default_nettype none

module tsa_datapath
  import tsa_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic signed [31:0] angle,
  input  wire logic [2:0]         term_count,
  input  wire logic               bad,
  input  wire dp_op_t             op,
  output dp_flags_t               flags,
  output logic signed [31:0]      sine,
  output logic                    status
);

  localparam int SH = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int XW = 32 + SH;               // widened angle
  localparam int DW = 31 + SH;               // distance beyond pi
  localparam int QB = SH + 1;                // turn-count bits
  localparam int QS = RECIP_2PI_SH - SH;     // scale of the turn estimate

  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sd2147483648);

  typedef enum logic [1:0] {SIDE_NONE, SIDE_POS, SIDE_NEG} side_t;

  logic signed [XW-1:0] x_r, x_nxt;
  logic [DW-1:0]        rem_r, rem_nxt;
  side_t                side_r, side_nxt;
  logic signed [31:0]   xr_r, xr_nxt;
  logic signed [MB-1:0] x2_r, x2_nxt;
  logic signed [MA-1:0] u_r, u_nxt;
  logic signed [31:0]   t_r, t_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [2:0]           i_r, i_nxt;
  logic [2:0]           n_r, n_nxt;
  logic                 bad_r, bad_nxt;

  logic signed [XW:0]   x_ext;
  logic signed [XW:0]   pi_ext;
  logic signed [32:0]   m_ext;
  logic signed [32:0]   pi33;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic                 mul_en;
  logic [2:0]           ridx;

  assign x_ext  = (XW + 1)'(x_r);
  assign pi_ext = $signed({{(XW - 30){1'b0}}, PI_Q});
  assign m_ext  = $signed({2'b00, rem_r[30:0]});
  assign pi33   = $signed({2'b00, PI_Q});
  assign ridx   = i_r - 3'd1;

  // Operand selection for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = MA'(t_r);
    mul_b  = x2_r;
    case (op)
      OP_MUL_DR: begin
        // turn-count estimate, never above the true count and at most one below
        mul_en = 1'b1;
        mul_a  = $signed({{(MA - 31){1'b0}}, rem_r[DW-1:SH]});
        mul_b  = $signed({1'b0, RECIP_2PI});
      end
      OP_MUL_QP: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MA - QB){1'b0}}, prod[QS+QB-1:QS]});
        mul_b  = $signed({2'b00, TWO_PI_Q});
      end
      OP_MUL_XX: begin
        mul_en = 1'b1;
        mul_a  = MA'(xr_r);
        mul_b  = MB'(xr_r);
      end
      OP_MUL_TX2: begin
        mul_en = 1'b1;
        mul_a  = MA'(t_r);
        mul_b  = x2_r;
      end
      OP_MUL_UR: begin
        mul_en = 1'b1;
        mul_a  = u_r;
        mul_b  = $signed({{(MB - 28){1'b0}}, recip_q30(ridx)});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  tsa_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign rnd = rnd_shr(prod, (op == OP_RND_T));

  // Next-value logic for each step
  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    side_nxt = side_r;
    xr_nxt   = xr_r;
    x2_nxt   = x2_r;
    u_nxt    = u_r;
    t_nxt    = t_r;
    sum_nxt  = sum_r;
    i_nxt    = i_r;
    n_nxt    = n_r;
    bad_nxt  = bad_r;
    if (load) begin
      x_nxt   = XW'(angle) <<< SH;
      n_nxt   = term_count;
      bad_nxt = bad;
    end
    case (op)
      OP_PREP: begin
        if (x_ext > pi_ext) begin
          side_nxt = SIDE_POS;
          rem_nxt  = DW'(x_ext - pi_ext);
        end else if (x_ext < -pi_ext) begin
          side_nxt = SIDE_NEG;
          rem_nxt  = DW'(-pi_ext - x_ext);
        end else begin
          side_nxt = SIDE_NONE;
          rem_nxt  = '0;
        end
      end
      // distance less whole turns, then at most one more turn off
      OP_REM: rem_nxt = rem_r - prod[DW-1:0];
      OP_CORR: begin
        if (rem_r >= DW'(TWO_PI_Q)) begin
          rem_nxt = rem_r - DW'(TWO_PI_Q);
        end
      end
      OP_FIX: begin
        case (side_r)
          SIDE_POS: xr_nxt = (rem_r == '0) ? 32'(pi33) : 32'(m_ext - pi33);
          SIDE_NEG: xr_nxt = (rem_r == '0) ? 32'(-pi33) : 32'(pi33 - m_ext);
          default:  xr_nxt = x_r[31:0];
        endcase
        t_nxt   = xr_nxt;
        sum_nxt = SW'(xr_nxt);
        i_nxt   = 3'd1;
      end
      OP_RND_X2: x2_nxt = rnd[MB-1:0];
      OP_RND_U:  u_nxt  = rnd[MA-1:0];
      OP_RND_T:  t_nxt  = -rnd[31:0];
      OP_ACC: begin
        sum_nxt = sum_r + SW'(t_r);
        i_nxt   = i_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    side_r <= side_nxt;
    xr_r   <= xr_nxt;
    x2_r   <= x2_nxt;
    u_r    <= u_nxt;
    t_r    <= t_nxt;
    sum_r  <= sum_nxt;
    i_r    <= i_nxt;
    n_r    <= n_nxt;
    bad_r  <= bad_nxt;
  end

  // Flags for the sequencer
  assign flags.one_term   = (n_r == 3'd1);
  assign flags.more_terms = (({1'b0, i_r} + 4'd1) < {1'b0, n_r});

  // Saturated result; zero for a bad term count
  always_comb begin
    if (bad_r) begin
      sine = '0;
    end else if (sum_r > SAT_MAX) begin
      sine = 32'sh7fffffff;
    end else if (sum_r < SAT_MIN) begin
      sine = 32'sh80000000;
    end else begin
      sine = sum_r[31:0];
    end
  end

  assign status = bad_r;

endmodule

`default_nettype wire

/* rtl/taylor_sine_approximator.sv */
// Top level of the Taylor-series sine block: handshakes and the output register.
// Depends on tsa_pkg, tsa_ucode_seq, tsa_datapath.
//
//  channel   direction  handshake          word
//  in_       input      in_valid/in_stall   in_angle (Q7.24), in_term_count
//  out_      output     out_valid/out_stall out_sine_value (Q3.28), out_status
//
// An item runs through a control ROM, one step per cycle unless held, on a single shared
// multiplier. Range reduction takes six steps (turn count by reciprocal multiply, multiply
// back by 2*pi, subtract, one correction, fold); x squared two steps, each further term
// five steps. A single term goes from the fold to the final step, which a bad count
// enters at once. Reset (synchronous, rst_n low) empties the sequencer and the output
// register. A stalled result waits in the output register while the next word is already
// taken in; that word's final step then waits for the register to free.
`timescale 1ns / 1ps
`default_nettype none

module taylor_sine_approximator
  import tsa_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_angle,
  input  wire logic [2:0]         in_term_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_sine_value,
  output logic                    out_status
);

  logic               busy;
  logic               accept;
  logic               bad;
  logic               out_hold;
  dp_op_t             exec_op;
  dp_flags_t          flags;
  logic signed [31:0] dp_sine;
  logic               dp_status;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_sine_value_r, out_sine_value_nxt;
  logic               out_status_r, out_status_nxt;

  // Input side
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign bad      = (in_term_count == 3'd0) || (in_term_count > MAX_TERM_COUNT);
  assign out_hold = out_valid_r && out_stall;

  tsa_ucode_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .start_bad (bad),
    .out_hold  (out_hold),
    .flags     (flags),
    .busy      (busy),
    .exec_op   (exec_op)
  );

  tsa_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .load       (accept),
    .angle      (in_angle),
    .term_count (in_term_count),
    .bad        (bad),
    .op         (exec_op),
    .flags      (flags),
    .sine       (dp_sine),
    .status     (dp_status)
  );

  // Output register
  always_comb begin
    out_valid_nxt      = out_valid_r;
    out_sine_value_nxt = out_sine_value_r;
    out_status_nxt     = out_status_r;
    if (exec_op == OP_DONE) begin
      out_valid_nxt      = 1'b1;
      out_sine_value_nxt = dp_sine;
      out_status_nxt     = dp_status;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sine_value_r <= out_sine_value_nxt;
    out_status_r     <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sine_value = out_sine_value_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

/* rtl/tsa_checker.sv */
// Port-level checker for the Taylor sine block, bound to the top level.
// Depends on taylor_sine_approximator_macros.svh and taylor_sine_approximator.
`timescale 1ns / 1ps
`default_nettype none

`include "taylor_sine_approximator_macros.svh"

module tsa_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_sine_value,
  input wire logic               out_status
);

  // A stalled result word holds
  `TSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sine_value) && $stable(out_status))

  // A bad term count always reports zero
  `TSA_ASSERT_NOW(a_bad_zero, out_valid && out_status, out_sine_value == 32'sd0)

  // One word in flight: taking a word closes the input
  `TSA_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

endmodule

bind taylor_sine_approximator tsa_checker u_tsa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sine_value (out_sine_value),
  .out_status     (out_status)
);

`default_nettype wire
